// ----- design/dmfp_pkg.sv -----
// Shared types and codes for the DNS message field parser
`timescale 1ns / 1ps

package dmfp_pkg;

	// parse phases
	localparam logic [3:0] PH_HEADER     = 4'd0;
	localparam logic [3:0] PH_NAME       = 4'd1;
	localparam logic [3:0] PH_NAME_AFTER = 4'd2;
	localparam logic [3:0] PH_LABEL      = 4'd3;
	localparam logic [3:0] PH_PTR_LOW    = 4'd4;
	localparam logic [3:0] PH_TYPE       = 4'd5;
	localparam logic [3:0] PH_CLASS      = 4'd6;
	localparam logic [3:0] PH_TTL        = 4'd7;
	localparam logic [3:0] PH_RDLEN      = 4'd8;
	localparam logic [3:0] PH_RDATA      = 4'd9;
	localparam logic [3:0] PH_DONE       = 4'd10;
	localparam logic [3:0] PH_IDLE       = 4'd11;

	// result kinds
	localparam logic [3:0] K_ID          = 4'd0;
	localparam logic [3:0] K_FLAGS       = 4'd1;
	localparam logic [3:0] K_QDCOUNT     = 4'd2;
	localparam logic [3:0] K_LABEL_BYTE  = 4'd6;
	localparam logic [3:0] K_LABEL_END   = 4'd7;
	localparam logic [3:0] K_NAME_END    = 4'd8;
	localparam logic [3:0] K_POINTER     = 4'd9;
	localparam logic [3:0] K_TYPE        = 4'd10;
	localparam logic [3:0] K_CLASS       = 4'd11;
	localparam logic [3:0] K_TTL         = 4'd12;
	localparam logic [3:0] K_RDLENGTH    = 4'd13;
	localparam logic [3:0] K_RDATA_BYTE  = 4'd14;
	localparam logic [3:0] K_SHORT_ERROR = 4'd15;

	// header layout
	localparam logic [3:0] HDR_LAST_POS  = 4'd11;
	localparam logic [7:0] OPCODE_MASK   = 8'h78;
	localparam logic [7:0] RCODE_MASK    = 8'h0f;

	// one result item
	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic [1:0]  section;
		logic [15:0] record_number;
		logic [3:0]  opcode;
		logic [3:0]  response_code;
		logic [6:0]  header_flags;
	} result_t;

endpackage

// ----- design/dns_message_field_parser.sv -----
// DNS message field parser: header decode and section walk, one byte per transfer
//
// Slave side takes one message byte per transfer: s_tdata carries the byte,
// s_tuser marks the first byte of a message and s_tlast the last one.
// Master side gives at most one field per input byte: m_tuser holds the field
// kind and m_tdata the value, section, record index and the header extras.
// Throughput is one byte per cycle while results are taken; every byte is
// handled by a single pass of logic between the input stage register and the
// result register. A byte's transfer loads the input stage register, and the
// result register loads from it once its previous result is taken; bytes that
// yield no field simply leave no result.
// Reset (arst_n low) puts the parser back to header byte 0 and empties both
// stages. A start mark restarts parsing on any byte.
// While the receiver stalls, the result register holds and the input stage
// still takes one more byte; s_tready then drops until the result is taken.
`timescale 1ns / 1ps

module dns_message_field_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] message_start
	input  logic        s_tlast,   // message_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [31:0] field_value, [33:32] section,
	                               // [49:34] record_number, [53:50] opcode,
	                               // [57:54] response_code, [64:58] header_flags,
	                               // [71:65] zero
	output logic [3:0]  m_tuser    // [3:0] field_kind
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       end_s1;

	// result stage
	logic             valid_s2;
	dmfp_pkg::result_t res_s2;

	// parser state
	logic [3:0]       phase_q;
	logic [3:0]       hdr_pos_q;
	logic [1:0]       fbc_q;
	logic [31:0]      shifter_q;
	logic [3:0][15:0] counts_q;
	logic [1:0]       cur_sec_q;
	logic [15:0]      rec_left_q;
	logic [5:0]       lbl_left_q;
	logic [15:0]      rd_left_q;

	// next state and result
	logic [3:0]       ph;
	logic [3:0]       hp;
	logic [1:0]       fbc;
	logic [31:0]      vs;
	logic [3:0][15:0] cnt;
	logic [1:0]       cs;
	logic [15:0]      rl;
	logic [5:0]       lbl;
	logic [15:0]      rdl;
	logic             r_valid;
	dmfp_pkg::result_t r;

	logic       advance;
	logic       do_finish;
	logic       do_enter;
	logic [2:0] enter_first;
	logic [2:0] pick;
	logic [15:0] rec_num;
	logic [1:0]  need;
	logic [3:0]  idx_raw;

	// lowest section at or after first with a non-zero count: {found, section}
	function automatic logic [2:0] pick_section(input logic [3:0][15:0] counts,
	                                            input logic [2:0] first);
		logic [2:0] res;
		res = '0;
		for (int s = 3; s >= 0; s--) begin
			if (3'(s) >= first && counts[s] != 16'd0) begin
				res = {1'b1, 2'(s)};
			end
		end
		return res;
	endfunction

	// handshake: the result stage moves on advance; the input stage also fills when empty
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {7'd0, res_s2.header_flags, res_s2.response_code, res_s2.opcode,
	                   res_s2.record_number, res_s2.section, res_s2.value};

	// byte decode
	always_comb begin
		ph  = phase_q;
		hp  = hdr_pos_q;
		fbc = fbc_q;
		vs  = shifter_q;
		cnt = counts_q;
		cs  = cur_sec_q;
		rl  = rec_left_q;
		lbl = lbl_left_q;
		rdl = rd_left_q;
		r_valid     = 1'b0;
		r           = '0;
		do_finish   = 1'b0;
		do_enter    = 1'b0;
		enter_first = 3'd0;
		pick        = 3'd0;
		need        = 2'd1;
		idx_raw     = hdr_pos_q - 4'd5;

		// start mark restarts from header byte 0
		if (start_s1) begin
			ph  = dmfp_pkg::PH_HEADER;
			hp  = 4'd0;
			fbc = 2'd0;
			vs  = 32'd0;
			cnt = '0;
			cs  = 2'd0;
			rl  = 16'd0;
			lbl = 6'd0;
			rdl = 16'd0;
		end
		idx_raw = hp - 4'd5;
		rec_num = cnt[cs] - rl;
		r.section       = cs;
		r.record_number = rec_num;

		case (ph)
			dmfp_pkg::PH_HEADER: begin
				r.section       = 2'd0;
				r.record_number = 16'd0;
				vs = {vs[23:0], byte_s1};
				if (hp == 4'd1) begin
					r_valid = 1'b1;
					r.kind  = dmfp_pkg::K_ID;
					r.value = {16'd0, vs[15:0]};
					vs = 32'd0;
				end else if (hp == 4'd3) begin
					r_valid = 1'b1;
					r.kind  = dmfp_pkg::K_FLAGS;
					r.value = {16'd0, vs[15:0]};
					r.opcode        = 4'((vs[15:8] & dmfp_pkg::OPCODE_MASK) >> 3);
					r.response_code = 4'(vs[7:0] & dmfp_pkg::RCODE_MASK);
					r.header_flags  = {vs[15], vs[10], vs[9], vs[8], vs[7], vs[5], vs[4]};
					vs = 32'd0;
				end else if (hp >= 4'd5 && hp[0]) begin
					cnt[idx_raw[2:1]] = vs[15:0];
					r_valid = 1'b1;
					r.kind  = dmfp_pkg::K_QDCOUNT + {2'd0, idx_raw[2:1]};
					r.value = {16'd0, vs[15:0]};
					vs = 32'd0;
				end
				if (hp >= dmfp_pkg::HDR_LAST_POS) begin
					hp          = 4'd0;
					do_enter    = 1'b1;
					enter_first = 3'd0;
				end else begin
					hp = hp + 4'd1;
				end
			end
			dmfp_pkg::PH_NAME, dmfp_pkg::PH_NAME_AFTER: begin
				r.kind  = dmfp_pkg::K_LABEL_END;
				r.value = {26'd0, vs[5:0]};
				if (byte_s1[7:6] == 2'b11) begin
					r_valid = (ph == dmfp_pkg::PH_NAME_AFTER);
					vs = {26'd0, byte_s1[5:0]};
					ph = dmfp_pkg::PH_PTR_LOW;
				end else if (byte_s1[5:0] == 6'd0) begin
					r_valid = 1'b1;
					r.kind  = dmfp_pkg::K_NAME_END;
					r.value = 32'd0;
					vs  = 32'd0;
					fbc = 2'd0;
					ph  = dmfp_pkg::PH_TYPE;
				end else begin
					r_valid = (ph == dmfp_pkg::PH_NAME_AFTER);
					lbl = byte_s1[5:0];
					vs  = {26'd0, byte_s1[5:0]};
					ph  = dmfp_pkg::PH_LABEL;
				end
			end
			dmfp_pkg::PH_LABEL: begin
				r_valid = 1'b1;
				r.kind  = dmfp_pkg::K_LABEL_BYTE;
				r.value = {24'd0, byte_s1};
				lbl = lbl - 6'd1;
				if (lbl == 6'd0) begin
					ph = dmfp_pkg::PH_NAME_AFTER;
				end
			end
			dmfp_pkg::PH_PTR_LOW: begin
				r_valid = 1'b1;
				r.kind  = dmfp_pkg::K_POINTER;
				r.value = {18'd0, vs[5:0], byte_s1};
				vs  = 32'd0;
				fbc = 2'd0;
				ph  = dmfp_pkg::PH_TYPE;
			end
			dmfp_pkg::PH_TYPE, dmfp_pkg::PH_CLASS, dmfp_pkg::PH_TTL, dmfp_pkg::PH_RDLEN: begin
				need = (ph == dmfp_pkg::PH_TTL) ? 2'd3 : 2'd1;
				vs = {vs[23:0], byte_s1};
				if (fbc < need) begin
					fbc = fbc + 2'd1;
				end else begin
					fbc     = 2'd0;
					r_valid = 1'b1;
					r.value = {16'd0, vs[15:0]};
					if (ph == dmfp_pkg::PH_TYPE) begin
						r.kind = dmfp_pkg::K_TYPE;
						ph = dmfp_pkg::PH_CLASS;
					end else if (ph == dmfp_pkg::PH_CLASS) begin
						r.kind = dmfp_pkg::K_CLASS;
						if (cs == 2'd0) begin
							do_finish = 1'b1;
						end else begin
							ph = dmfp_pkg::PH_TTL;
						end
					end else if (ph == dmfp_pkg::PH_TTL) begin
						r.kind  = dmfp_pkg::K_TTL;
						r.value = vs;
						ph = dmfp_pkg::PH_RDLEN;
					end else begin
						r.kind = dmfp_pkg::K_RDLENGTH;
						rdl = vs[15:0];
						if (vs[15:0] == 16'd0) begin
							do_finish = 1'b1;
						end else begin
							ph = dmfp_pkg::PH_RDATA;
						end
					end
					vs = 32'd0;
				end
			end
			dmfp_pkg::PH_RDATA: begin
				r_valid = 1'b1;
				r.kind  = dmfp_pkg::K_RDATA_BYTE;
				r.value = {24'd0, byte_s1};
				rdl = rdl - 16'd1;
				if (rdl == 16'd0) begin
					do_finish = 1'b1;
				end
			end
			default: begin
				r.section       = 2'd0;
				r.record_number = 16'd0;
			end
		endcase

		// end of a record: next record or next non-empty section
		if (do_finish) begin
			rl = rl - 16'd1;
			if (rl == 16'd0) begin
				do_enter    = 1'b1;
				enter_first = {1'b0, cs} + 3'd1;
			end else begin
				ph = dmfp_pkg::PH_NAME;
			end
		end
		if (do_enter) begin
			pick = pick_section(cnt, enter_first);
			if (pick[2]) begin
				cs = pick[1:0];
				rl = cnt[pick[1:0]];
				ph = dmfp_pkg::PH_NAME;
			end else begin
				ph = dmfp_pkg::PH_DONE;
			end
		end

		// end mark: short error inside the header, then wait for a start
		if (end_s1) begin
			if (ph == dmfp_pkg::PH_HEADER) begin
				r_valid = 1'b1;
				r       = '0;
				r.kind  = dmfp_pkg::K_SHORT_ERROR;
				r.value = {28'd0, hp};
			end
			ph  = dmfp_pkg::PH_IDLE;
			hp  = 4'd0;
			vs  = 32'd0;
			fbc = 2'd0;
		end
	end

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
			end_s1   <= s_tlast;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= r;
		end
	end

	// parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= dmfp_pkg::PH_HEADER;
			hdr_pos_q  <= 4'd0;
			fbc_q      <= 2'd0;
			shifter_q  <= 32'd0;
			counts_q   <= '0;
			cur_sec_q  <= 2'd0;
			rec_left_q <= 16'd0;
			lbl_left_q <= 6'd0;
			rd_left_q  <= 16'd0;
		end else if (advance && valid_s1) begin
			phase_q    <= ph;
			hdr_pos_q  <= hp;
			fbc_q      <= fbc;
			shifter_q  <= vs;
			counts_q   <= cnt;
			cur_sec_q  <= cs;
			rec_left_q <= rl;
			lbl_left_q <= lbl;
			rd_left_q  <= rdl;
		end
	end

	// checks
	a_short_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == dmfp_pkg::K_SHORT_ERROR) |->
			(m_tdata[49:32] == 18'd0 && m_tdata[31:0] < 32'd12))
		else $error("short error carries record fields or a bad byte count");

	a_flags_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == dmfp_pkg::K_FLAGS) |->
			(m_tdata[53:50] == m_tdata[14:11] && m_tdata[57:54] == m_tdata[3:0]))
		else $error("opcode or response code does not match the flags word");

	a_extras_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != dmfp_pkg::K_FLAGS) |-> (m_tdata[71:50] == 22'd0))
		else $error("header extras set on a non-flags field");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input stalled without a blocked result");

	a_hdr_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_pos_q <= dmfp_pkg::HDR_LAST_POS)
		else $error("header position past the header");

endmodule
